// File: src/dscmp_pkg.sv
// Package for the dice sum counter: shared types, modulus constants and the
// small constant tables. Used by every module of the block by scoped names.
package dscmp_pkg;

   localparam logic [29:0] WAY_MOD    = 30'd1000000007;
   localparam logic [31:0] WAY_MOD_X2 = 32'd2000000014;
   // Barrett factor: floor(2^60 / WAY_MOD).
   localparam logic [30:0] BARRETT_MU = 31'd1152921496;
   localparam logic [2:0]  DIM_LAST   = 3'd5;

   localparam logic [1:0] BANK_ACC_INIT  = 2'd0;
   localparam logic [1:0] BANK_PW_INIT   = 2'd1;
   localparam logic [1:0] BANK_FREE_INIT = 2'd2;

   // Matrix memory address: bank, row, column.
   typedef logic [7:0] addr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_INIT_ACC,
      ST_INIT_PW,
      ST_CHECK,
      ST_MUL,
      ST_MUL_WAIT,
      ST_DOT,
      ST_DOT_WAIT,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic       issue;
      addr_type   a_addr;
      addr_type   b_addr;
      addr_type   w_addr;
      logic       first;
      logic       last;
      logic       use_seed;
      logic [2:0] seed_idx;
      logic       init_wr;
      logic       init_bit;
      logic       load_small;
      logic [2:0] small_idx;
   } cmd_type;

   typedef struct packed {
      logic     valid;
      logic     first;
      logic     last;
      logic     use_seed;
      addr_type w_addr;
   } stage_ctl_type;

   function automatic logic [29:0] small_sum(input logic [2:0] idx);
      logic [29:0] val;
      begin
         case (idx)
            3'd1:    val = 30'd1;
            3'd2:    val = 30'd2;
            3'd3:    val = 30'd4;
            3'd4:    val = 30'd8;
            3'd5:    val = 30'd16;
            3'd6:    val = 30'd32;
            default: val = 30'd0;
         endcase
         return val;
      end
   endfunction

   function automatic logic [29:0] seed_value(input logic [2:0] idx);
      logic [29:0] val;
      begin
         case (idx)
            3'd0:    val = 30'd32;
            3'd1:    val = 30'd16;
            3'd2:    val = 30'd8;
            3'd3:    val = 30'd4;
            3'd4:    val = 30'd2;
            3'd5:    val = 30'd1;
            default: val = 30'd0;
         endcase
         return val;
      end
   endfunction

endpackage

// File: src/dscmp_dp.sv
// Datapath of the dice sum counter: matrix memory and the pipelined modular
// multiply-accumulate unit with Barrett reduction. Depends on dscmp_pkg.
module dscmp_dp (
   input  logic              clock,
   input  logic              reset,
   input  dscmp_pkg::cmd_type cmd,
   output logic              pipe_idle,
   output logic [29:0]       result
);

   logic [29:0] mat_ram_ff [0:255];

   logic [29:0] rda_ff;
   logic [29:0] rdb_ff;
   logic [29:0] seed1_ff;
   logic [59:0] prod_ff;
   logic [61:0] q1_ff;
   logic [31:0] p3_ff;
   logic [31:0] p4_ff;
   logic [31:0] qm_ff;
   logic [31:0] r_ff;
   logic [29:0] red_ff;
   logic [29:0] acc_ff;
   logic [29:0] result_ff;

   dscmp_pkg::stage_ctl_type ctl0;
   dscmp_pkg::stage_ctl_type ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff, ctl6_ff;

   logic [29:0] opb;
   logic [59:0] prod_in;
   logic [61:0] q1_in;
   logic [60:0] qm_full;
   logic [31:0] qm_in;
   logic [31:0] r_in;
   logic [29:0] red_in;
   logic [30:0] sum;
   logic [29:0] acc_in;

   assign ctl0 = '{valid: cmd.issue, first: cmd.first, last: cmd.last,
                   use_seed: cmd.use_seed, w_addr: cmd.w_addr};

   always_comb begin
      opb     = ctl1_ff.use_seed ? seed1_ff : rdb_ff;
      prod_in = {30'b0, rda_ff} * {30'b0, opb};
      q1_in   = {31'b0, prod_ff[59:29]} * {31'b0, dscmp_pkg::BARRETT_MU};
      qm_full = {30'b0, q1_ff[61:31]} * {31'b0, dscmp_pkg::WAY_MOD};
      qm_in   = qm_full[31:0];
      r_in    = p4_ff - qm_ff;
      if (r_ff >= dscmp_pkg::WAY_MOD_X2) begin
         red_in = 30'(r_ff - dscmp_pkg::WAY_MOD_X2);
      end else if (r_ff >= {2'b0, dscmp_pkg::WAY_MOD}) begin
         red_in = 30'(r_ff - {2'b0, dscmp_pkg::WAY_MOD});
      end else begin
         red_in = r_ff[29:0];
      end
      sum = {1'b0, (ctl6_ff.first ? 30'd0 : acc_ff)} + {1'b0, red_ff};
      if (sum >= {1'b0, dscmp_pkg::WAY_MOD}) begin
         acc_in = 30'(sum - {1'b0, dscmp_pkg::WAY_MOD});
      end else begin
         acc_in = sum[29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_wr) begin
         mat_ram_ff[cmd.w_addr] <= {29'b0, cmd.init_bit};
      end else if (ctl6_ff.valid && ctl6_ff.last && !ctl6_ff.use_seed) begin
         mat_ram_ff[ctl6_ff.w_addr] <= acc_in;
      end
      rda_ff <= mat_ram_ff[cmd.a_addr];
      rdb_ff <= mat_ram_ff[cmd.b_addr];
   end

   always_ff @(posedge clock) begin
      seed1_ff <= dscmp_pkg::seed_value(cmd.seed_idx);
      prod_ff  <= prod_in;
      q1_ff    <= q1_in;
      p3_ff    <= prod_ff[31:0];
      p4_ff    <= p3_ff;
      qm_ff    <= qm_in;
      r_ff     <= r_in;
      red_ff   <= red_in;
      if (ctl6_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (cmd.load_small) begin
         result_ff <= dscmp_pkg::small_sum(cmd.small_idx);
      end else if (ctl6_ff.valid && ctl6_ff.last && ctl6_ff.use_seed) begin
         result_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
         ctl3_ff.valid <= 1'b0;
         ctl4_ff.valid <= 1'b0;
         ctl5_ff.valid <= 1'b0;
         ctl6_ff.valid <= 1'b0;
      end else begin
         ctl1_ff <= ctl0;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
         ctl5_ff <= ctl4_ff;
         ctl6_ff <= ctl5_ff;
      end
   end

   assign pipe_idle = !(ctl1_ff.valid || ctl2_ff.valid || ctl3_ff.valid ||
                        ctl4_ff.valid || ctl5_ff.valid || ctl6_ff.valid);
   assign result    = result_ff;

endmodule

// File: src/dscmp_ctrl.sv
// Controller of the dice sum counter: sequences matrix set-up, the
// square-and-multiply passes and the final dot product. Depends on dscmp_pkg.
module dscmp_ctrl #(
   parameter int unsigned EXP_BITS = 60
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [EXP_BITS-1:0]  req_target_sum,
   input  logic                 pipe_idle,
   output logic                 busy,
   output logic                 rsp_valid,
   output dscmp_pkg::cmd_type   cmd
);

   dscmp_pkg::state_type state_ff, state_in;

   logic [EXP_BITS-1:0] ex_ff, ex_in;
   logic [2:0] i_ff, i_in;
   logic [2:0] j_ff, j_in;
   logic [2:0] k_ff, k_in;
   logic       op_sq_ff, op_sq_in;
   logic [1:0] acc_bank_ff, acc_bank_in;
   logic [1:0] pw_bank_ff, pw_bank_in;
   logic [1:0] free_bank_ff, free_bank_in;

   logic small_sum;
   logic i_last, j_last, k_last;

   assign small_sum = (ex_ff <= EXP_BITS'(6));
   assign i_last    = (i_ff == dscmp_pkg::DIM_LAST);
   assign j_last    = (j_ff == dscmp_pkg::DIM_LAST);
   assign k_last    = (k_ff == dscmp_pkg::DIM_LAST);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dscmp_pkg::ST_IDLE: begin
            if (start) state_in = dscmp_pkg::ST_SETUP;
         end
         dscmp_pkg::ST_SETUP: begin
            state_in = small_sum ? dscmp_pkg::ST_RESPOND : dscmp_pkg::ST_INIT_ACC;
         end
         dscmp_pkg::ST_INIT_ACC: begin
            if (i_last && j_last) state_in = dscmp_pkg::ST_INIT_PW;
         end
         dscmp_pkg::ST_INIT_PW: begin
            if (i_last && j_last) state_in = dscmp_pkg::ST_CHECK;
         end
         dscmp_pkg::ST_CHECK: begin
            state_in = (ex_ff == '0) ? dscmp_pkg::ST_DOT : dscmp_pkg::ST_MUL;
         end
         dscmp_pkg::ST_MUL: begin
            if (i_last && j_last && k_last) state_in = dscmp_pkg::ST_MUL_WAIT;
         end
         dscmp_pkg::ST_MUL_WAIT: begin
            if (pipe_idle) state_in = dscmp_pkg::ST_CHECK;
         end
         dscmp_pkg::ST_DOT: begin
            if (k_last) state_in = dscmp_pkg::ST_DOT_WAIT;
         end
         dscmp_pkg::ST_DOT_WAIT: begin
            if (pipe_idle) state_in = dscmp_pkg::ST_RESPOND;
         end
         dscmp_pkg::ST_RESPOND: begin
            state_in = dscmp_pkg::ST_IDLE;
         end
         default: begin
            state_in = dscmp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ex_in        = ex_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      op_sq_in     = op_sq_ff;
      acc_bank_in  = acc_bank_ff;
      pw_bank_in   = pw_bank_ff;
      free_bank_in = free_bank_ff;
      unique case (state_ff) inside
         dscmp_pkg::ST_IDLE: begin
            if (start) ex_in = req_target_sum;
         end
         dscmp_pkg::ST_SETUP: begin
            ex_in        = ex_ff - EXP_BITS'(6);
            i_in         = 3'd0;
            j_in         = 3'd0;
            k_in         = 3'd0;
            acc_bank_in  = dscmp_pkg::BANK_ACC_INIT;
            pw_bank_in   = dscmp_pkg::BANK_PW_INIT;
            free_bank_in = dscmp_pkg::BANK_FREE_INIT;
         end
         dscmp_pkg::ST_INIT_ACC, dscmp_pkg::ST_INIT_PW: begin
            j_in = j_last ? 3'd0 : j_ff + 3'd1;
            if (j_last) i_in = i_last ? 3'd0 : i_ff + 3'd1;
         end
         dscmp_pkg::ST_CHECK: begin
            op_sq_in = !ex_ff[0];
         end
         dscmp_pkg::ST_MUL: begin
            k_in = k_last ? 3'd0 : k_ff + 3'd1;
            if (k_last) begin
               j_in = j_last ? 3'd0 : j_ff + 3'd1;
               if (j_last) i_in = i_last ? 3'd0 : i_ff + 3'd1;
            end
         end
         dscmp_pkg::ST_MUL_WAIT: begin
            if (pipe_idle) begin
               if (op_sq_ff) begin
                  pw_bank_in   = free_bank_ff;
                  free_bank_in = pw_bank_ff;
                  ex_in        = ex_ff >> 1;
               end else begin
                  acc_bank_in  = free_bank_ff;
                  free_bank_in = acc_bank_ff;
                  ex_in        = {ex_ff[EXP_BITS-1:1], 1'b0};
               end
            end
         end
         dscmp_pkg::ST_DOT: begin
            k_in = k_last ? 3'd0 : k_ff + 3'd1;
         end
         dscmp_pkg::ST_DOT_WAIT, dscmp_pkg::ST_RESPOND: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = (state_ff != dscmp_pkg::ST_IDLE);
      rsp_valid = (state_ff == dscmp_pkg::ST_RESPOND);
      unique case (state_ff) inside
         dscmp_pkg::ST_SETUP: begin
            cmd.load_small = small_sum;
            cmd.small_idx  = ex_ff[2:0];
         end
         dscmp_pkg::ST_INIT_ACC: begin
            cmd.init_wr  = 1'b1;
            cmd.w_addr   = {acc_bank_ff, i_ff, j_ff};
            cmd.init_bit = (i_ff == j_ff);
         end
         dscmp_pkg::ST_INIT_PW: begin
            cmd.init_wr  = 1'b1;
            cmd.w_addr   = {pw_bank_ff, i_ff, j_ff};
            cmd.init_bit = (i_ff == 3'd0) || (j_ff == i_ff - 3'd1);
         end
         dscmp_pkg::ST_MUL: begin
            cmd.issue  = 1'b1;
            cmd.a_addr = op_sq_ff ? {pw_bank_ff, i_ff, k_ff} : {acc_bank_ff, i_ff, k_ff};
            cmd.b_addr = {pw_bank_ff, k_ff, j_ff};
            cmd.w_addr = {free_bank_ff, i_ff, j_ff};
            cmd.first  = (k_ff == 3'd0);
            cmd.last   = k_last;
         end
         dscmp_pkg::ST_DOT: begin
            cmd.issue    = 1'b1;
            cmd.a_addr   = {acc_bank_ff, 3'd0, k_ff};
            cmd.use_seed = 1'b1;
            cmd.seed_idx = k_ff;
            cmd.first    = (k_ff == 3'd0);
            cmd.last     = k_last;
         end
         dscmp_pkg::ST_IDLE, dscmp_pkg::ST_CHECK, dscmp_pkg::ST_MUL_WAIT,
         dscmp_pkg::ST_DOT_WAIT, dscmp_pkg::ST_RESPOND: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dscmp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ex_ff        <= ex_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      op_sq_ff     <= op_sq_in;
      acc_bank_ff  <= acc_bank_in;
      pw_bank_ff   <= pw_bank_in;
      free_bank_ff <= free_bank_in;
   end

endmodule

// File: src/dice_sum_count_matrix_power_top.sv
// Top level of the dice sum counter: joins the controller and the datapath.
// Depends on dscmp_pkg, dscmp_ctrl and dscmp_dp.
//
// A request is taken at a rising edge where start is high and busy is low;
// req_target_sum carries the sum n. Busy stays high until the response has
// been given. The response, the number of ordered die sequences summing to n
// modulo 1000000007, appears on rsp_way_count for exactly one cycle with
// rsp_valid high; the receiver cannot stall it, so it must take it then.
// For n up to 6 the response is read from a small table.
// Otherwise the block computes L - 1 + P modular matrix products, where L is the
// bit length of n - 6 and P its count of set bits: each 6x6 modular matrix
// product takes 216 multiply-accumulates through the one shared pipelined
// multiply-accumulate unit, and the pipeline drains before the next pass.
// One request is worked on at a time.
// Synchronous reset returns the controller to idle and empties the pipeline;
// nothing is kept from one request to the next.
module dice_sum_count_matrix_power_top #(
   parameter int unsigned EXP_BITS = 60
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [EXP_BITS-1:0] req_target_sum,
   output logic                busy,
   output logic                rsp_valid,
   output logic [29:0]         rsp_way_count
);

   dscmp_pkg::cmd_type cmd;
   logic               pipe_idle;

   dscmp_ctrl #(
      .EXP_BITS(EXP_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_target_sum(req_target_sum),
      .pipe_idle     (pipe_idle),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .cmd           (cmd)
   );

   dscmp_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .pipe_idle(pipe_idle),
      .result   (rsp_way_count)
   );

endmodule

// File: src/dscmp_checker.sv
// Port checker for the dice sum counter, bound to the top level.
// Depends on dscmp_pkg and dice_sum_count_matrix_power_top.
module dscmp_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [29:0] rsp_way_count
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted request did not raise busy.");

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("Response given while not busy.");

   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("Response was not followed by return to idle.");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_way_count < dscmp_pkg::WAY_MOD))
      else $error("Response value not reduced below the modulus.");

endmodule

bind dice_sum_count_matrix_power_top dscmp_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_way_count(rsp_way_count)
);
